FILE: rtl/core/lzssd_pkg.sv
`timescale 1ns / 1ps

package lzssd_pkg;

    // stream phase codes
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_TOKEN  = 2'd1;
    localparam logic [1:0] PH_MATCH2 = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam int unsigned MIN_MATCH = 3;
    localparam int unsigned OFFSET_W  = 12;
    localparam int unsigned LEN_W     = 5;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned FLAG_W    = 9;

    localparam logic [FLAG_W-1:0] FLAG_EMPTY = FLAG_W'(1);
    localparam logic [FLAG_W-1:0] FLAG_MARK  = FLAG_W'(9'h100);

    function automatic logic [7:0] rot_right1(input logic [7:0] v);
        rot_right1 = {v[0], v[7:1]};
    endfunction

endpackage

FILE: rtl/core/lzssd_ram.sv
`timescale 1ns / 1ps

module lzssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/lzss_byte_decoder_with_rotate.sv
`timescale 1ns / 1ps

// LZSS stream decoder: takes one compressed byte per word on the s_ channel
// (4-byte little-endian size header, then flag bytes read LSB first, literals
// and two-byte matches with a 12-bit offset and a 4-bit length plus three) and
// returns decompressed bytes one per word on the m_ channel, optionally rotated
// right by one bit under cfg_wr_data. A second match byte copies N bytes (N up
// to 18), each a registered read and then a write of the history RAM of
// WINDOW_DEPTH bytes; a stalled m_ channel holds a literal or a copied byte.
// s_ready is high only while no word is in work. The history RAM needs no
// clearing after reset.
module lzss_byte_decoder_with_rotate #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_stream_start,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_stream_done
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_DEPTH - 1);
    localparam logic [AW-1:0] PTR_WRAP = AW'(WINDOW_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PROC = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_WR   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] hdr_idx_reg, hdr_idx_next;
    logic [lzssd_pkg::COUNT_W-1:0] target_reg, target_next;
    logic [lzssd_pkg::COUNT_W-1:0] produced_reg, produced_next;
    logic [lzssd_pkg::FLAG_W-1:0] flag_reg, flag_next;
    logic [7:0] pair_first_reg, pair_first_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [7:0] byte_reg, byte_next;
    logic [lzssd_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic [lzssd_pkg::LEN_W-1:0] cnt_reg, cnt_next;
    logic zero_fill_reg, zero_fill_next;
    logic rotate_reg;

    logic m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg, m_byte_next;
    logic m_last_reg, m_last_next;
    logic m_done_reg, m_done_next;

    logic out_free;
    logic emit_en;
    logic emit_last;
    logic [7:0] emit_value;
    logic ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0] ram_rd_data;
    logic [AW:0] addr_diff;
    logic [lzssd_pkg::OFFSET_W-1:0] pair_offset;
    logic [lzssd_pkg::LEN_W-1:0] pair_len;
    logic [lzssd_pkg::COUNT_W-1:0] left;
    logic [lzssd_pkg::COUNT_W-1:0] hdr_target;

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_run_last    = m_last_reg;
    assign m_stream_done = m_done_reg;
    assign out_free      = !m_valid_reg || m_ready;

    assign addr_diff = {1'b0, wr_ptr_reg} - (AW + 1)'(offset_reg);
    assign ram_rd_addr = addr_diff[AW] ? (addr_diff[AW-1:0] + PTR_WRAP) : addr_diff[AW-1:0];
    assign ram_rd_en = (state_reg == S_RD);

    assign pair_offset = {byte_reg, pair_first_reg[7:4]};
    assign pair_len = lzssd_pkg::LEN_W'(pair_first_reg[3:0]) + lzssd_pkg::LEN_W'(lzssd_pkg::MIN_MATCH);
    assign left = target_reg - produced_reg;

    always_comb begin
        hdr_target = target_reg;
        case (hdr_idx_reg)
            2'd0: hdr_target[7:0]   = target_reg[7:0] | byte_reg;
            2'd1: hdr_target[15:8]  = target_reg[15:8] | byte_reg;
            2'd2: hdr_target[23:16] = target_reg[23:16] | byte_reg;
            default: hdr_target[31:24] = target_reg[31:24] | byte_reg;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        hdr_idx_next    = hdr_idx_reg;
        target_next     = target_reg;
        produced_next   = produced_reg;
        flag_next       = flag_reg;
        pair_first_next = pair_first_reg;
        wr_ptr_next     = wr_ptr_reg;
        byte_next       = byte_reg;
        offset_next     = offset_reg;
        cnt_next        = cnt_reg;
        zero_fill_next  = zero_fill_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_byte_next     = m_byte_reg;
        m_last_next     = m_last_reg;
        m_done_next     = m_done_reg;
        emit_en         = 1'b0;
        emit_last       = 1'b0;
        emit_value      = byte_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    byte_next  = s_in_byte;
                    state_next = S_PROC;
                    if (s_stream_start) begin
                        phase_next      = lzssd_pkg::PH_HEADER;
                        hdr_idx_next    = 2'd0;
                        target_next     = '0;
                        produced_next   = '0;
                        flag_next       = lzssd_pkg::FLAG_EMPTY;
                        pair_first_next = '0;
                        wr_ptr_next     = '0;
                    end
                end
            end
            S_PROC: begin
                state_next = S_IDLE;
                case (phase_reg)
                    lzssd_pkg::PH_HEADER: begin
                        target_next  = hdr_target;
                        hdr_idx_next = hdr_idx_reg + 2'd1;
                        if (hdr_idx_reg == 2'd3) begin
                            phase_next = (hdr_target == '0) ? lzssd_pkg::PH_DONE
                                                            : lzssd_pkg::PH_TOKEN;
                        end
                    end
                    lzssd_pkg::PH_TOKEN: begin
                        if (flag_reg == lzssd_pkg::FLAG_EMPTY) begin
                            flag_next = lzssd_pkg::FLAG_MARK | lzssd_pkg::FLAG_W'(byte_reg);
                        end else if (flag_reg[0]) begin
                            if (out_free) begin
                                flag_next  = flag_reg >> 1;
                                emit_en    = 1'b1;
                                emit_last  = 1'b1;
                                emit_value = byte_reg;
                            end else begin
                                state_next = S_PROC;
                            end
                        end else begin
                            flag_next       = flag_reg >> 1;
                            pair_first_next = byte_reg;
                            phase_next      = lzssd_pkg::PH_MATCH2;
                        end
                    end
                    lzssd_pkg::PH_MATCH2: begin
                        phase_next     = lzssd_pkg::PH_TOKEN;
                        offset_next    = pair_offset;
                        cnt_next       = (left < lzssd_pkg::COUNT_W'(pair_len))
                                         ? left[lzssd_pkg::LEN_W-1:0] : pair_len;
                        zero_fill_next = (pair_offset == '0) ||
                                         (lzssd_pkg::COUNT_W'(pair_offset) > produced_reg);
                        state_next     = S_RD;
                    end
                    default: begin
                    end
                endcase
            end
            S_RD: begin
                state_next = S_WR;
            end
            S_WR: begin
                if (out_free) begin
                    emit_en    = 1'b1;
                    emit_last  = (cnt_reg == lzssd_pkg::LEN_W'(1));
                    emit_value = zero_fill_reg ? 8'd0 : ram_rd_data;
                    cnt_next   = cnt_reg - lzssd_pkg::LEN_W'(1);
                    state_next = emit_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (emit_en) begin
            produced_next = produced_reg + lzssd_pkg::COUNT_W'(1);
            wr_ptr_next   = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + AW'(1);
            m_valid_next  = 1'b1;
            m_byte_next   = rotate_reg ? lzssd_pkg::rot_right1(emit_value) : emit_value;
            m_last_next   = emit_last;
            m_done_next   = (produced_next == target_reg);
            if (produced_next == target_reg) begin
                phase_next = lzssd_pkg::PH_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            phase_reg       <= lzssd_pkg::PH_HEADER;
            hdr_idx_reg     <= 2'd0;
            target_reg      <= '0;
            produced_reg    <= '0;
            flag_reg        <= lzssd_pkg::FLAG_EMPTY;
            pair_first_reg  <= '0;
            wr_ptr_reg      <= '0;
            cnt_reg         <= '0;
            zero_fill_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
            rotate_reg      <= 1'b1;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            hdr_idx_reg     <= hdr_idx_next;
            target_reg      <= target_next;
            produced_reg    <= produced_next;
            flag_reg        <= flag_next;
            pair_first_reg  <= pair_first_next;
            wr_ptr_reg      <= wr_ptr_next;
            cnt_reg         <= cnt_next;
            zero_fill_reg   <= zero_fill_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                rotate_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        offset_reg <= offset_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_done_reg <= m_done_next;
    end

    lzssd_ram #(
        .WIDTH(8),
        .DEPTH(WINDOW_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (emit_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (emit_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    a_load_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_PROC || $past(state_reg) == S_WR))
        else $error("output loaded outside an emitting state");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        produced_reg <= target_reg)
        else $error("produced count passed the declared size");

    a_copy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD || state_reg == S_WR) |-> (cnt_reg != '0))
        else $error("copy loop running with zero count");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_done_reg) |-> m_last_reg)
        else $error("stream end not on the last word of its run");

endmodule
